// ===== sv/bal_pkg.sv =====
// Shared types, opcode ranges and register indexes for the byte ALU.
package bal_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [DataW-1:0] byte_t;

  // Fixed opcode ranges
  localparam byte_t AddLo   = 8'h70;
  localparam byte_t AddHi   = 8'h78;
  localparam byte_t IncLo   = 8'hC0;
  localparam byte_t IncHi   = 8'hC7;
  localparam byte_t SubLo   = 8'h80;
  localparam byte_t SubHi   = 8'h88;
  localparam byte_t CmpLo   = 8'hA8;
  localparam byte_t CmpHi   = 8'hAF;
  localparam byte_t DecLo   = 8'hC8;
  localparam byte_t DecHi   = 8'hCF;
  localparam byte_t AndLo   = 8'h90;
  localparam byte_t AndHi   = 8'h97;
  localparam byte_t AndXLo  = 8'hB8;
  localparam byte_t AndXHi  = 8'hBF;
  localparam byte_t OrLo    = 8'h98;
  localparam byte_t OrHi    = 8'h9F;
  localparam byte_t XorLo   = 8'hA0;
  localparam byte_t XorHi   = 8'hA7;

  // Reset values of the opcode registers
  localparam byte_t CmpImmRst = 8'hB0;
  localparam byte_t ShlRst    = 8'hD0;
  localparam byte_t ShrRst    = 8'hD1;
  localparam byte_t RolRst    = 8'hD2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CMP_IMM = 2'd0,
    CFG_SHL     = 2'd1,
    CFG_SHR     = 2'd2,
    CFG_ROL     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_INC,
    OP_SUB,
    OP_DEC,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_SHL,
    OP_SHR,
    OP_ROL
  } op_e;

  typedef struct packed {
    byte_t cmp_imm_code;
    byte_t shl_code;
    byte_t shr_code;
    byte_t rol_code;
  } codes_t;

  typedef struct packed {
    byte_t cmd;
    byte_t operand_a;
    byte_t opnd_b;
    logic  carry_in;
    logic  overflow_in;
    logic  zero_in;
    logic  sign_in;
  } in_t;

  typedef struct packed {
    byte_t result_byte;
    logic  carry_out;
    logic  overflow_out;
    logic  zero_out;
    logic  sign_out;
    logic  recognized;
  } out_t;

endpackage

// ===== sv/byte_alu_with_status_flags_unit.sv =====
// Top level of the byte ALU: input register, decode and execute, result register.
//
// Eight-bit ALU with carry, overflow, zero and sign flags. An item is taken
// on every clock edge with start_i high (busy_o stays low, so one item per
// cycle sustained); its result shows on result_o with done_o high for exactly
// one cycle, once the item has passed the input register and then decode and
// execute into the result register. The receiver cannot stall, so results must
// be taken as they appear. Opcode registers for compare immediate, shift left,
// shift right and rotate left are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write them only while no item is in flight; the block does not check.
module byte_alu_with_status_flags_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  bal_pkg::in_t                 item_i,
  output logic                         done_o,
  output bal_pkg::out_t                result_o,
  input  logic                         cfg_we_i,
  input  logic [bal_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  bal_pkg::byte_t               cfg_wdata_i
);

  bal_pkg::codes_t codes_q;
  logic            valid_q;
  bal_pkg::in_t    item_q;
  logic            done_q;
  bal_pkg::out_t   res_q, res_d;
  bal_pkg::op_e    op;
  logic            accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.cmp_imm_code <= bal_pkg::CmpImmRst;
      codes_q.shl_code     <= bal_pkg::ShlRst;
      codes_q.shr_code     <= bal_pkg::ShrRst;
      codes_q.rol_code     <= bal_pkg::RolRst;
    end else if (cfg_we_i) begin
      case (bal_pkg::cfg_idx_e'(cfg_idx_i))
        bal_pkg::CFG_CMP_IMM: codes_q.cmp_imm_code <= cfg_wdata_i;
        bal_pkg::CFG_SHL:     codes_q.shl_code     <= cfg_wdata_i;
        bal_pkg::CFG_SHR:     codes_q.shr_code     <= cfg_wdata_i;
        bal_pkg::CFG_ROL:     codes_q.rol_code     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  // Payload registers: input captures on accept, result on valid_q; both hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  bal_decode u_decode (
    .cmd_i   (item_q.cmd),
    .codes_i (codes_q),
    .op_o    (op)
  );

  bal_exec u_exec (
    .op_i   (op),
    .item_i (item_q),
    .res_o  (res_d)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted item produced no result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q))
    else $error("result strobe without an item in the input register");

  a_unrec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.recognized) |-> (result_o.result_byte == '0))
    else $error("unrecognized opcode gave a nonzero result");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.recognized) |->
      ((result_o.zero_out == (result_o.result_byte == '0)) &&
       (result_o.sign_out == result_o.result_byte[7])))
    else $error("zero or sign flag disagrees with result byte");

endmodule

// ===== sv/bal_decode.sv =====
// Opcode classifier: maps the command byte to an operation by priority.
module bal_decode (
  input  bal_pkg::byte_t  cmd_i,
  input  bal_pkg::codes_t codes_i,
  output bal_pkg::op_e    op_o
);

  function automatic logic in_rng(bal_pkg::byte_t v, bal_pkg::byte_t lo, bal_pkg::byte_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

  always_comb begin
    if (in_rng(cmd_i, bal_pkg::AddLo, bal_pkg::AddHi)) begin
      op_o = bal_pkg::OP_ADD;
    end else if (in_rng(cmd_i, bal_pkg::IncLo, bal_pkg::IncHi)) begin
      op_o = bal_pkg::OP_INC;
    end else if (in_rng(cmd_i, bal_pkg::DecLo, bal_pkg::DecHi)) begin
      // Keep decrement ahead so a compare-immediate code in its range still subtracts one
      op_o = bal_pkg::OP_DEC;
    end else if (in_rng(cmd_i, bal_pkg::SubLo, bal_pkg::SubHi) ||
                 in_rng(cmd_i, bal_pkg::CmpLo, bal_pkg::CmpHi) ||
                 (cmd_i == codes_i.cmp_imm_code)) begin
      op_o = bal_pkg::OP_SUB;
    end else if (in_rng(cmd_i, bal_pkg::AndLo, bal_pkg::AndHi) ||
                 in_rng(cmd_i, bal_pkg::AndXLo, bal_pkg::AndXHi)) begin
      op_o = bal_pkg::OP_AND;
    end else if (in_rng(cmd_i, bal_pkg::OrLo, bal_pkg::OrHi)) begin
      op_o = bal_pkg::OP_OR;
    end else if (in_rng(cmd_i, bal_pkg::XorLo, bal_pkg::XorHi)) begin
      op_o = bal_pkg::OP_XOR;
    end else if (cmd_i == codes_i.shl_code) begin
      op_o = bal_pkg::OP_SHL;
    end else if (cmd_i == codes_i.shr_code) begin
      op_o = bal_pkg::OP_SHR;
    end else if (cmd_i == codes_i.rol_code) begin
      op_o = bal_pkg::OP_ROL;
    end else begin
      op_o = bal_pkg::OP_NONE;
    end
  end

endmodule

// ===== sv/bal_exec.sv =====
// Datapath: computes result byte and flags for a decoded operation.
module bal_exec (
  input  bal_pkg::op_e  op_i,
  input  bal_pkg::in_t  item_i,
  output bal_pkg::out_t res_o
);

  logic [bal_pkg::DataW-1:0] a, b, m;
  logic [bal_pkg::DataW:0]   sum, diff;
  logic [bal_pkg::DataW-1:0] r;
  logic                      c, v;

  assign a = item_i.operand_a;
  assign b = item_i.opnd_b;
  // Inc and dec use a constant one in place of operand b
  assign m = ((op_i == bal_pkg::OP_INC) || (op_i == bal_pkg::OP_DEC)) ?
             bal_pkg::DataW'(1) : b;
  assign sum  = {1'b0, a} + {1'b0, m};
  assign diff = {1'b0, a} - {1'b0, m};

  always_comb begin
    r = '0;
    c = 1'b0;
    v = 1'b0;
    case (op_i)
      bal_pkg::OP_ADD, bal_pkg::OP_INC: begin
        r = sum[bal_pkg::DataW-1:0];
        c = sum[bal_pkg::DataW];
        v = ~(a[7] ^ m[7]) & (a[7] ^ r[7]);
      end
      bal_pkg::OP_SUB, bal_pkg::OP_DEC: begin
        r = diff[bal_pkg::DataW-1:0];
        c = diff[bal_pkg::DataW];  // borrow
        v = (a[7] ^ m[7]) & (a[7] ^ r[7]);
      end
      bal_pkg::OP_AND: r = a & b;
      bal_pkg::OP_OR:  r = a | b;
      bal_pkg::OP_XOR: r = a ^ b;
      bal_pkg::OP_SHL: begin
        r = {a[6:0], 1'b0};
        c = a[7];
      end
      bal_pkg::OP_SHR: begin
        r = {1'b0, a[7:1]};
        c = a[0];
      end
      bal_pkg::OP_ROL: begin
        r = {a[6:0], item_i.carry_in};
        c = a[7];
      end
      default: begin
        r = '0;
        c = 1'b0;
        v = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (op_i == bal_pkg::OP_NONE) begin
      // Pass the incoming flags through untouched
      res_o.result_byte  = '0;
      res_o.carry_out    = item_i.carry_in;
      res_o.overflow_out = item_i.overflow_in;
      res_o.zero_out     = item_i.zero_in;
      res_o.sign_out     = item_i.sign_in;
      res_o.recognized   = 1'b0;
    end else begin
      res_o.result_byte  = r;
      res_o.carry_out    = c;
      res_o.overflow_out = v;
      res_o.zero_out     = (r == '0);
      res_o.sign_out     = r[7];
      res_o.recognized   = 1'b1;
    end
  end

endmodule
